FILE: design/act_pkg.sv
// Package for the aging client table: entry and control types, action and
// register codes, state encoding. No dependencies.
`timescale 1ns / 1ps

package act_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W    = 16;
    localparam int MODE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int POS_W     = 8;
    localparam int LIMIT_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 5'd16;
    localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd5000;

    // Action codes; code seven is unused and does nothing
    typedef enum logic [2:0] {
        ACT_ADD      = 3'd0,
        ACT_REM_ADDR = 3'd1,
        ACT_REM_IDX  = 3'd2,
        ACT_LOOKUP   = 3'd3,
        ACT_REFRESH  = 3'd4,
        ACT_SWEEP    = 3'd5,
        ACT_READ     = 3'd6
    } t_action;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIMEOUT = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    // One table entry
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] seen;
    } t_entry;

    // Command word presented to every cell
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] timeout;
    } t_query;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic wr_new;     // load the new entry
        logic wr_stamp;   // restamp last-seen time
        logic kill_load;  // load the kill mark
        logic kill_val;   // value for the kill mark
        logic shift;      // take entry and mark from the next cell
    } t_cell_ctl;

endpackage

FILE: design/act_cell.sv
// One cell of the aging client table: holds one entry and its kill mark,
// matches and ages locally, and passes hit and kill chains on. Uses act_pkg.
`timescale 1ns / 1ps

module act_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  act_pkg::t_cell_ctl i_ctl,
    input  act_pkg::t_query    i_query,
    input  act_pkg::t_entry    i_next,
    input  logic               i_next_kill,
    input  logic               i_live,
    input  logic               i_prior_hit,
    input  logic               i_prior_kill,
    output act_pkg::t_entry    o_entry,
    output logic               o_kill,
    output logic               o_first,
    output logic               o_stale,
    output logic               o_hit_chain,
    output logic               o_kill_chain
);

    act_pkg::t_entry r_entry;
    logic            r_kill;
    logic            w_match;
    logic [act_pkg::TIME_W-1:0] w_age;

    // Local compare and age
    assign w_match      = i_live && (r_entry.addr == i_query.addr);
    assign w_age        = i_query.now - r_entry.seen;
    assign o_stale      = i_live && (w_age > i_query.timeout);
    assign o_first      = w_match && !i_prior_hit;
    assign o_hit_chain  = i_prior_hit | w_match;
    assign o_kill_chain = i_prior_kill | r_kill;
    assign o_entry      = r_entry;
    assign o_kill       = r_kill;

    // Entry storage: shift down, load new, or restamp
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_next;
        end else if (i_ctl.wr_new) begin
            r_entry.addr <= i_query.addr;
            r_entry.mode <= i_query.mode;
            r_entry.seen <= i_query.now;
        end else if (i_ctl.wr_stamp) begin
            r_entry.seen <= i_query.now;
        end
    end

    // Kill mark travels with the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kill <= 1'b0;
        end else if (i_ctl.kill_load) begin
            r_kill <= i_ctl.kill_val;
        end else if (i_ctl.shift) begin
            r_kill <= i_next_kill;
        end
    end

endmodule

FILE: design/aging_client_table.sv
// Aging client table top level: sequencer, configuration registers and a
// row of act_cell entries. Uses act_pkg and act_cell.
`timescale 1ns / 1ps

//  channel   direction  handshake                 payload
//  in        to block   i_in_valid / o_in_ready   action, address, index, mode, time
//  out       from block o_out_valid / i_out_ready success, index, address, mode, counts
//  cfg       to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  A word passes from acceptance through the execute and done states to the
//  output register; a removal or sweep adds the sweep state, one shift per removal.
//  Only one word is in work at a time; the next is taken while a result waits.
//  Synchronous active-low reset empties the table; no clearing pass.
//  Configuration writes are taken in any cycle outside reset.

module aging_client_table #(
    parameter int MAX_CLIENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [15:0] i_client_address,
    input  logic [7:0]  i_entry_index,
    input  logic [7:0]  i_ranging_mode,
    input  logic [31:0] i_now_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_success,
    output logic [7:0]  o_found_index,
    output logic [15:0] o_entry_address,
    output logic [7:0]  o_entry_mode,
    output logic [7:0]  o_client_count,
    output logic [7:0]  o_removed_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_CLIENTS + 1);

    // Control registers
    act_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ov, n_ov;
    logic [4:0]      r_limit;
    logic [31:0]     r_timeout;

    // Captured word
    logic [2:0]  r_act, n_act;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_idx, n_idx;
    logic [7:0]  r_mode, n_mode;
    logic [31:0] r_now, n_now;

    // Result being built
    logic        r_ok, n_ok;
    logic [7:0]  r_pos, n_pos;
    logic [15:0] r_raddr, n_raddr;
    logic [7:0]  r_rmode, n_rmode;
    logic [7:0]  r_rem, n_rem;

    // Output register
    logic        r_o_ok, n_o_ok;
    logic [7:0]  r_o_pos, n_o_pos;
    logic [15:0] r_o_addr, n_o_addr;
    logic [7:0]  r_o_mode, n_o_mode;
    logic [7:0]  r_o_count, n_o_count;
    logic [7:0]  r_o_rem, n_o_rem;

    // Cell row signals
    act_pkg::t_query    w_query;
    act_pkg::t_entry    w_entry [MAX_CLIENTS];
    act_pkg::t_cell_ctl w_ctl [MAX_CLIENTS];
    logic [MAX_CLIENTS-1:0] w_kill, w_first, w_stale, w_hit_chain, w_kill_chain;
    logic [MAX_CLIENTS-1:0] w_live, w_at_count, w_sel_idx, w_pick;
    logic [MAX_CLIENTS-1:0] w_wr_new, w_wr_stamp, w_kill_load, w_kill_val, w_shift;
    logic        w_any_hit, w_any_kill, w_idx_ok, w_can_add;
    logic [7:0]  w_hit_pos;
    logic [15:0] w_pick_addr;
    logic [7:0]  w_pick_mode;

    assign w_query = '{addr: r_addr, mode: r_mode, now: r_now, timeout: r_timeout};

    // Row of cells, chained on hit, kill and shift data
    for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_cell
        act_pkg::t_entry w_next;
        logic            w_next_kill;
        logic            w_prior_hit;
        logic            w_prior_kill;

        assign w_live[i]     = CW'(i) < r_count;
        assign w_at_count[i] = CW'(i) == r_count;
        assign w_sel_idx[i]  = r_idx == 8'(i);
        assign w_ctl[i]      = '{wr_new: w_wr_new[i], wr_stamp: w_wr_stamp[i],
                                 kill_load: w_kill_load[i], kill_val: w_kill_val[i],
                                 shift: w_shift[i]};

        if (i == MAX_CLIENTS - 1) begin : g_tail
            assign w_next      = w_entry[i];
            assign w_next_kill = 1'b0;
        end else begin : g_body
            assign w_next      = w_entry[i+1];
            assign w_next_kill = w_kill[i+1];
        end

        if (i == 0) begin : g_head
            assign w_prior_hit  = 1'b0;
            assign w_prior_kill = 1'b0;
        end else begin : g_link
            assign w_prior_hit  = w_hit_chain[i-1];
            assign w_prior_kill = w_kill_chain[i-1];
        end

        act_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[i]),
            .i_query      (w_query),
            .i_next       (w_next),
            .i_next_kill  (w_next_kill),
            .i_live       (w_live[i]),
            .i_prior_hit  (w_prior_hit),
            .i_prior_kill (w_prior_kill),
            .o_entry      (w_entry[i]),
            .o_kill       (w_kill[i]),
            .o_first      (w_first[i]),
            .o_stale      (w_stale[i]),
            .o_hit_chain  (w_hit_chain[i]),
            .o_kill_chain (w_kill_chain[i])
        );
    end

    assign w_any_hit  = w_hit_chain[MAX_CLIENTS-1];
    assign w_any_kill = w_kill_chain[MAX_CLIENTS-1];
    assign w_idx_ok   = 9'(r_idx) < 9'(r_count);
    assign w_can_add  = !w_any_hit && (9'(r_count) < 9'(r_limit))
                        && (9'(r_count) < 9'(MAX_CLIENTS));

    // Entry selection: by index for index actions, else first address hit
    assign w_pick = ((r_act == act_pkg::ACT_REM_IDX) || (r_act == act_pkg::ACT_READ))
                    ? w_sel_idx : w_first;

    always_comb begin
        w_pick_addr = '0;
        w_pick_mode = '0;
        w_hit_pos   = '0;
        for (int k = 0; k < MAX_CLIENTS; k++) begin
            if (w_pick[k]) begin
                w_pick_addr = w_pick_addr | w_entry[k].addr;
                w_pick_mode = w_pick_mode | w_entry[k].mode;
            end
            if (w_first[k]) begin
                w_hit_pos = w_hit_pos | 8'(k);
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ov        = r_ov;
        n_act       = r_act;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_mode      = r_mode;
        n_now       = r_now;
        n_ok        = r_ok;
        n_pos       = r_pos;
        n_raddr     = r_raddr;
        n_rmode     = r_rmode;
        n_rem       = r_rem;
        n_o_ok      = r_o_ok;
        n_o_pos     = r_o_pos;
        n_o_addr    = r_o_addr;
        n_o_mode    = r_o_mode;
        n_o_count   = r_o_count;
        n_o_rem     = r_o_rem;
        w_wr_new    = '0;
        w_wr_stamp  = '0;
        w_kill_load = '0;
        w_kill_val  = '0;
        w_shift     = '0;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            act_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_act   = i_action;
                    n_addr  = i_client_address;
                    n_idx   = i_entry_index;
                    n_mode  = i_ranging_mode;
                    n_now   = i_now_time;
                    n_state = act_pkg::ST_EXEC;
                end
            end
            act_pkg::ST_EXEC: begin
                n_ok    = 1'b0;
                n_pos   = '0;
                n_raddr = '0;
                n_rmode = '0;
                n_rem   = '0;
                n_state = act_pkg::ST_DONE;
                case (r_act)
                    act_pkg::ACT_ADD: begin
                        if (w_can_add) begin
                            w_wr_new = w_at_count;
                            n_count  = r_count + CW'(1);
                            n_ok     = 1'b1;
                            n_pos    = 8'(r_count);
                            n_raddr  = r_addr;
                            n_rmode  = r_mode;
                        end
                    end
                    act_pkg::ACT_REM_ADDR: begin
                        if (w_any_hit) begin
                            w_kill_load = '1;
                            w_kill_val  = w_first;
                            n_ok        = 1'b1;
                            n_pos       = w_hit_pos;
                            n_raddr     = w_pick_addr;
                            n_rmode     = w_pick_mode;
                            n_state     = act_pkg::ST_SWEEP;
                        end
                    end
                    act_pkg::ACT_REM_IDX: begin
                        if (w_idx_ok) begin
                            w_kill_load = '1;
                            w_kill_val  = w_sel_idx;
                            n_ok        = 1'b1;
                            n_pos       = r_idx;
                            n_raddr     = w_pick_addr;
                            n_rmode     = w_pick_mode;
                            n_state     = act_pkg::ST_SWEEP;
                        end
                    end
                    act_pkg::ACT_LOOKUP, act_pkg::ACT_REFRESH: begin
                        if (w_any_hit) begin
                            if (r_act == act_pkg::ACT_REFRESH) begin
                                w_wr_stamp = w_first;
                            end
                            n_ok    = 1'b1;
                            n_pos   = w_hit_pos;
                            n_raddr = w_pick_addr;
                            n_rmode = w_pick_mode;
                        end
                    end
                    act_pkg::ACT_SWEEP: begin
                        w_kill_load = '1;
                        w_kill_val  = w_stale;
                        n_state     = act_pkg::ST_SWEEP;
                    end
                    act_pkg::ACT_READ: begin
                        if (w_idx_ok) begin
                            n_ok    = 1'b1;
                            n_pos   = r_idx;
                            n_raddr = w_pick_addr;
                            n_rmode = w_pick_mode;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            act_pkg::ST_SWEEP: begin
                // drop the first marked entry; later cells move down one
                if (w_any_kill) begin
                    w_shift = w_kill_chain;
                    n_count = r_count - CW'(1);
                    n_rem   = r_rem + 8'd1;
                    n_ok    = 1'b1;
                end else begin
                    n_state = act_pkg::ST_DONE;
                end
            end
            act_pkg::ST_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_o_ok    = r_ok;
                    n_o_pos   = r_pos;
                    n_o_addr  = r_raddr;
                    n_o_mode  = r_rmode;
                    n_o_count = 8'(r_count);
                    n_o_rem   = r_rem;
                    n_ov      = 1'b1;
                    n_state   = act_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = act_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= act_pkg::ST_IDLE;
            r_count   <= '0;
            r_ov      <= 1'b0;
            r_limit   <= act_pkg::LIMIT_RESET;
            r_timeout <= act_pkg::TIMEOUT_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    act_pkg::CFG_CLIENT_LIMIT:  r_limit   <= i_cfg_data[4:0];
                    act_pkg::CFG_STALE_TIMEOUT: r_timeout <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_addr    <= n_addr;
        r_idx     <= n_idx;
        r_mode    <= n_mode;
        r_now     <= n_now;
        r_ok      <= n_ok;
        r_pos     <= n_pos;
        r_raddr   <= n_raddr;
        r_rmode   <= n_rmode;
        r_rem     <= n_rem;
        r_o_ok    <= n_o_ok;
        r_o_pos   <= n_o_pos;
        r_o_addr  <= n_o_addr;
        r_o_mode  <= n_o_mode;
        r_o_count <= n_o_count;
        r_o_rem   <= n_o_rem;
    end

    assign o_in_ready      = (r_state == act_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_ov;
    assign o_success       = r_o_ok;
    assign o_found_index   = r_o_pos;
    assign o_entry_address = r_o_addr;
    assign o_entry_mode    = r_o_mode;
    assign o_client_count  = r_o_count;
    assign o_removed_count = r_o_rem;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        9'(r_count) <= 9'(MAX_CLIENTS))
        else $error("entry count above table depth");

    a_kill_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == act_pkg::ST_SWEEP) |-> ((w_kill & ~w_live) == '0))
        else $error("kill mark on an empty cell");

    a_sweep_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == act_pkg::ST_SWEEP && w_any_kill)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("removal did not drop the count by one");

    a_add_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == act_pkg::ST_EXEC && r_act == act_pkg::ACT_ADD && w_can_add)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("add did not grow the count by one");

    a_single_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first hit");

endmodule
